@@ sv/median_filter_2d_rgb_top_macros.svh @@
// Assertion helpers for the median filter checker.
`ifndef MEDIAN_FILTER_2D_RGB_TOP_MACROS_SVH
`define MEDIAN_FILTER_2D_RGB_TOP_MACROS_SVH

// Same-cycle implication.
`define MF_ASSERT_NOW(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("median filter check failed");

// Next-cycle implication.
`define MF_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("median filter check failed");

`endif

@@ sv/mf2d_pkg.sv @@
package mf2d_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int MAX_RADIUS = 5;
  localparam int RING_ROWS  = 2 * MAX_RADIUS + 1;
  localparam int NUM_CH     = 3;

  localparam int X_W     = 10;
  localparam int Y_W     = 12;
  localparam int SLOT_W  = 4;
  localparam int ADDR_W  = SLOT_W + X_W;
  localparam int DEPTH   = RING_ROWS * MAX_WIDTH;
  localparam int PIX_W   = 24;
  localparam int CNT_W   = 7;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_RADIUS = 2'd2;

  typedef struct packed {
    logic       init;
    logic       acc;
    logic       decide;
    logic [2:0] bit_idx;
  } sel_ctrl_t;

endpackage

@@ sv/mf2d_store.sv @@
module mf2d_store
  import mf2d_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [PIX_W-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [PIX_W-1:0]  rdata
);

  logic [PIX_W-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ sv/mf2d_select.sv @@
module mf2d_select
  import mf2d_pkg::*;
(
  input  logic             clk,
  input  sel_ctrl_t        ctrl,
  input  logic [CNT_W-1:0] target,
  input  logic [PIX_W-1:0] sample,
  output logic [7:0]       median [NUM_CH]
);

  // One result bit per pass, MSB first: count samples that match the
  // prefix above the current bit and have a zero there.
  logic [7:0]       prefix [NUM_CH];
  logic [CNT_W-1:0] cnt    [NUM_CH];
  logic [CNT_W-1:0] rank   [NUM_CH];
  logic [8:0]       mask9;
  logic [7:0]       mask;

  assign mask9 = 9'h1FF << (4'({1'b0, ctrl.bit_idx}) + 4'd1);
  assign mask  = mask9[7:0];

  always_ff @(posedge clk) begin
    for (int c = 0; c < NUM_CH; c++) begin
      if (ctrl.init) begin
        prefix[c] <= 8'd0;
        cnt[c]    <= '0;
        rank[c]   <= target;
      end else if (ctrl.decide) begin
        cnt[c] <= '0;
        if (cnt[c] <= rank[c]) begin
          prefix[c][ctrl.bit_idx] <= 1'b1;
          rank[c] <= rank[c] - cnt[c];
        end
      end else if (ctrl.acc) begin
        if (((sample[8*c +: 8] & mask) == (prefix[c] & mask)) &&
            !sample[8*c + int'(ctrl.bit_idx)]) begin
          cnt[c] <= cnt[c] + 1'b1;
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      median[c] = prefix[c];
    end
  end

endmodule

@@ sv/median_filter_2d_rgb_top.sv @@
// Channel | Signals                                   | Direction
// cfg     | cfg_we, cfg_index, cfg_data               | write only
// pixel   | in_valid, in_stall, pixel_blue/green/red  | in
// result  | out_valid, out_stall, out_x, out_y, med.. | out
//
// One pixel at a time; each released output takes one store
// read per window sample per bit.
// Up to (r+1)^2 outputs per pixel at frame corners.
// Synchronous reset; row store contents are not cleared.
// A stalled result holds; a new pixel may arrive while a run's last waits.
module median_filter_2d_rgb_top
  import mf2d_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [12:0]  cfg_data,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [7:0]   pixel_blue,
  input  logic [7:0]   pixel_green,
  input  logic [7:0]   pixel_red,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [9:0]   out_x,
  output logic [11:0]  out_y,
  output logic [7:0]   median_blue,
  output logic [7:0]   median_green,
  output logic [7:0]   median_red,
  output logic         last_in_run
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_WRITE  = 6'b000010,
    ST_SCAN   = 6'b000100,
    ST_SETTLE = 6'b001000,
    ST_DECIDE = 6'b010000,
    ST_EMIT   = 6'b100000
  } state_t;

  state_t state;

  logic [10:0]       w_eff;
  logic [12:0]       h_eff;
  logic [2:0]        r_eff;
  logic [X_W-1:0]    cx, ox, xlo, xhi;
  logic [Y_W-1:0]    cy, oy, yhi;
  logic [SLOT_W-1:0] cy_slot;
  logic signed [13:0] wx, wy;
  logic [3:0]        dx_cnt, dy_cnt;
  logic [2:0]        bit_idx;
  logic              rd_vld;

  logic [X_W-1:0]    wm1;
  logic [Y_W-1:0]    hm1;
  logic [3:0]        span;
  logic [X_W-1:0]    r_x;
  logic [Y_W-1:0]    r_y;
  logic              last_col, last_row, xany, yany;
  logic [X_W-1:0]    xlo_c, xhi_c;
  logic [Y_W-1:0]    ylo_c, yhi_c;
  logic [X_W-1:0]    kx;
  logic [Y_W-1:0]    ky;
  logic [3:0]        row_back;
  logic [4:0]        slot_diff;
  logic [SLOT_W-1:0] rslot;
  logic [ADDR_W-1:0] raddr;
  logic [PIX_W-1:0]  rdata;
  logic [6:0]        r7;
  logic [CNT_W-1:0]  target;
  sel_ctrl_t         sctrl;
  logic [7:0]        med [NUM_CH];
  logic              in_acc, out_free, out_last;

  assign wm1  = X_W'(w_eff - 11'd1);
  assign hm1  = Y_W'(h_eff - 13'd1);
  assign span = {r_eff, 1'b0};
  assign r_x  = X_W'(r_eff);
  assign r_y  = Y_W'(r_eff);
  assign r7   = {4'd0, r_eff};
  assign target = CNT_W'((r7 * (r7 + 7'd1)) << 1);

  assign last_col = (cx == wm1);
  assign last_row = (cy == hm1);
  assign xany  = last_col || (cx >= r_x);
  assign yany  = last_row || (cy >= r_y);
  assign xlo_c = (cx >= r_x) ? cx - r_x : '0;
  assign xhi_c = last_col ? cx : xlo_c;
  assign ylo_c = (cy >= r_y) ? cy - r_y : '0;
  assign yhi_c = last_row ? cy : ylo_c;

  // clamp window coordinates into the frame
  always_comb begin
    if (wx < 0) kx = '0;
    else if (wx > $signed({4'd0, wm1})) kx = wm1;
    else kx = X_W'(wx);
    if (wy < 0) ky = '0;
    else if (wy > $signed({2'd0, hm1})) ky = hm1;
    else ky = Y_W'(wy);
  end

  // window rows sit at most 2r rows above the current input row
  assign row_back  = 4'(cy - ky);
  assign slot_diff = {1'b0, cy_slot} - {1'b0, row_back};
  assign rslot     = slot_diff[4] ? SLOT_W'(slot_diff + 5'(RING_ROWS)) : slot_diff[3:0];
  assign raddr     = {rslot, kx};

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign out_last = (ox == xhi) && (oy == yhi);

  assign sctrl.init    = (state == ST_WRITE) ||
                         ((state == ST_EMIT) && out_free && !out_last);
  assign sctrl.acc     = rd_vld;
  assign sctrl.decide  = (state == ST_DECIDE);
  assign sctrl.bit_idx = bit_idx;

  mf2d_store u_store (
    .clk   (clk),
    .we    (in_acc),
    .waddr ({cy_slot, cx}),
    .wdata ({pixel_red, pixel_green, pixel_blue}),
    .raddr (raddr),
    .rdata (rdata)
  );

  mf2d_select u_select (
    .clk    (clk),
    .ctrl   (sctrl),
    .target (target),
    .sample (rdata),
    .median (med)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      w_eff     <= 11'd640;
      h_eff     <= 13'd480;
      r_eff     <= 3'd1;
      cx        <= '0;
      cy        <= '0;
      cy_slot   <= '0;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_vld <= (state == ST_SCAN);
      if ((state == ST_EMIT) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      if (cfg_we) begin
        unique case (cfg_index)
          REG_WIDTH: begin
            if (cfg_data[10:0] == 11'd0) w_eff <= 11'd1;
            else if (cfg_data[10:0] > 11'(MAX_WIDTH)) w_eff <= 11'(MAX_WIDTH);
            else w_eff <= cfg_data[10:0];
            cx <= '0; cy <= '0; cy_slot <= '0;
          end
          REG_HEIGHT: begin
            if (cfg_data == 13'd0) h_eff <= 13'd1;
            else if (cfg_data > 13'(MAX_HEIGHT)) h_eff <= 13'(MAX_HEIGHT);
            else h_eff <= cfg_data;
            cx <= '0; cy <= '0; cy_slot <= '0;
          end
          REG_RADIUS: begin
            r_eff <= (cfg_data[2:0] > 3'(MAX_RADIUS)) ? 3'(MAX_RADIUS) : cfg_data[2:0];
            cx <= '0; cy <= '0; cy_slot <= '0;
          end
          default: ;
        endcase
      end

      unique case (state)
        ST_IDLE: begin
          if (in_acc) state <= ST_WRITE;
        end
        ST_WRITE: begin
          xlo <= xlo_c; xhi <= xhi_c; yhi <= yhi_c;
          ox  <= xlo_c; oy  <= ylo_c;
          wx  <= $signed({4'd0, xlo_c}) - $signed({11'd0, r_eff});
          wy  <= $signed({2'd0, ylo_c}) - $signed({11'd0, r_eff});
          dx_cnt <= '0; dy_cnt <= '0; bit_idx <= 3'd7;
          if (xany && yany) begin
            state <= ST_SCAN;
          end else begin
            state <= ST_IDLE;
            if (last_col) begin
              cx <= '0;
              if (last_row) begin
                cy <= '0; cy_slot <= '0;
              end else begin
                cy <= cy + 1'b1;
                cy_slot <= (cy_slot == SLOT_W'(RING_ROWS - 1)) ? '0 : cy_slot + 1'b1;
              end
            end else begin
              cx <= cx + 1'b1;
            end
          end
        end
        ST_SCAN: begin
          if (dx_cnt == span) begin
            dx_cnt <= '0;
            wx <= $signed({4'd0, ox}) - $signed({11'd0, r_eff});
            if (dy_cnt == span) begin
              state <= ST_SETTLE;
            end else begin
              dy_cnt <= dy_cnt + 1'b1;
              wy <= wy + 14'sd1;
            end
          end else begin
            dx_cnt <= dx_cnt + 1'b1;
            wx <= wx + 14'sd1;
          end
        end
        ST_SETTLE: begin
          state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          dy_cnt <= '0;
          wy <= $signed({2'd0, oy}) - $signed({11'd0, r_eff});
          if (bit_idx == 3'd0) begin
            state <= ST_EMIT;
          end else begin
            bit_idx <= bit_idx - 1'b1;
            state <= ST_SCAN;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_x        <= ox;
            out_y        <= oy;
            median_blue  <= med[0];
            median_green <= med[1];
            median_red   <= med[2];
            last_in_run  <= out_last;
            bit_idx <= 3'd7;
            dx_cnt  <= '0;
            dy_cnt  <= '0;
            if (out_last) begin
              state <= ST_IDLE;
              if (last_col) begin
                cx <= '0;
                if (last_row) begin
                  cy <= '0; cy_slot <= '0;
                end else begin
                  cy <= cy + 1'b1;
                  cy_slot <= (cy_slot == SLOT_W'(RING_ROWS - 1)) ? '0 : cy_slot + 1'b1;
                end
              end else begin
                cx <= cx + 1'b1;
              end
            end else begin
              state <= ST_SCAN;
              if (ox == xhi) begin
                ox <= xlo;
                oy <= oy + 1'b1;
                wx <= $signed({4'd0, xlo}) - $signed({11'd0, r_eff});
                wy <= $signed({2'd0, oy}) + 14'sd1 - $signed({11'd0, r_eff});
              end else begin
                ox <= ox + 1'b1;
                wx <= $signed({4'd0, ox}) + 14'sd1 - $signed({11'd0, r_eff});
                wy <= $signed({2'd0, oy}) - $signed({11'd0, r_eff});
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ sv/mf2d_checker.sv @@
`include "median_filter_2d_rgb_top_macros.svh"

module mf2d_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_we,
  input logic [1:0]  cfg_index,
  input logic [12:0] cfg_data,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  pixel_blue,
  input logic [7:0]  pixel_green,
  input logic [7:0]  pixel_red,
  input logic        out_valid,
  input logic        out_stall,
  input logic [9:0]  out_x,
  input logic [11:0] out_y,
  input logic [7:0]  median_blue,
  input logic [7:0]  median_green,
  input logic [7:0]  median_red,
  input logic        last_in_run
);

  // stalled result transaction is held
  `MF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_x) && $stable(out_y))
  // a pixel transaction is followed by a busy cycle
  `MF_ASSERT_NEXT(a_in_busy, in_valid && !in_stall, in_stall)
  // while a result that is not the last of its run is shown, the pixel side stays closed
  `MF_ASSERT_NOW(a_run_busy, out_valid && !last_in_run, in_stall)

endmodule

bind median_filter_2d_rgb_top mf2d_checker u_mf2d_checker (.*);
